FILE: design/rbps_pkg.sv
`default_nettype none

package rbps_pkg;

  localparam int unsigned AddrW = 16;
  localparam int unsigned BankW = 2;

  typedef enum logic [6:0] {
    MODE_DISABLED = 7'b0000001,
    MODE_ENABLED  = 7'b0000010,
    MODE_ALT2     = 7'b0000100,
    MODE_ALT3     = 7'b0001000,
    MODE_BIT1     = 7'b0010000,
    MODE_BIT2     = 7'b0100000,
    MODE_BIT3     = 7'b1000000
  } mode_e;

  localparam logic [AddrW-1:0] SEL_MASK   = 16'hffcf;
  localparam logic [AddrW-1:0] SEL_BASE   = 16'h0080;
  localparam logic [AddrW-1:0] ALT2_MASK  = 16'h1fff;
  localparam logic [AddrW-1:0] ALT2_VALUE = 16'h1dff;
  localparam logic [AddrW-1:0] ALT3_MASK  = 16'h1ffc;
  localparam logic [AddrW-1:0] ALT3_VALUE = 16'h1b5c;
  localparam logic [AddrW-1:0] ALT4_MASK  = 16'h1fcf;
  localparam logic [AddrW-1:0] ALT4_VALUE = 16'h0080;
  localparam logic [AddrW-1:0] BIT1_MASK  = 16'h1ff0;
  localparam logic [AddrW-1:0] BIT1_VALUE = 16'h1540;
  localparam logic [AddrW-1:0] BIT2_MASK  = 16'h1ff3;
  localparam logic [AddrW-1:0] BIT2_CLR0  = 16'h1540;
  localparam logic [AddrW-1:0] BIT2_SET0  = 16'h1541;
  localparam logic [AddrW-1:0] BIT2_CLR1  = 16'h1542;
  localparam logic [AddrW-1:0] BIT2_SET1  = 16'h1543;
  localparam logic [AddrW-1:0] BIT3_MASK  = 16'h1ff8;
  localparam logic [AddrW-1:0] BIT3_VALUE = 16'h1550;
  localparam logic [BankW-1:0] RESET_BANK = 2'd3;

  typedef struct packed {
    mode_e            mode;
    logic [BankW-1:0] bank;
    logic [BankW-1:0] alt_pend;
    logic [BankW-1:0] bit_pend;
    logic [BankW-1:0] toggle;
  } seq_state_t;

endpackage

`default_nettype wire

FILE: design/rbps_intf.sv
`default_nettype none

interface rbps_addr_if;
  logic        valid;
  logic        ready;
  logic [15:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface rbps_bank_if;
  logic       valid;
  logic       ready;
  logic [1:0] bank;

  modport source (output valid, output bank, input ready);
  modport sink   (input valid, input bank, output ready);
endinterface

`default_nettype wire

FILE: design/rbps_step.sv
`default_nettype none

module rbps_step (
  input  rbps_pkg::seq_state_t       state_i,
  input  logic [rbps_pkg::AddrW-1:0] addr_i,
  output rbps_pkg::seq_state_t       state_o
);
  import rbps_pkg::*;

  logic             sel_hit;
  logic [BankW-1:0] sel_bank;
  logic [AddrW-1:0] bit2_x;

  assign sel_hit  = (addr_i & SEL_MASK) == SEL_BASE;
  assign sel_bank = addr_i[5:4];
  // toggle mask flips the low address bits during bit updates
  assign bit2_x   = (addr_i ^ {{(AddrW-BankW){1'b0}}, state_i.toggle}) & BIT2_MASK;

  always_comb begin
    state_o = state_i;
    if (addr_i == '0) begin
      state_o.mode = MODE_ENABLED;
    end else begin
      case (state_i.mode)
        MODE_ENABLED: begin
          if ((addr_i & BIT1_MASK) == BIT1_VALUE) begin
            state_o.mode = MODE_BIT1;
          end else if ((addr_i & ALT2_MASK) == ALT2_VALUE) begin
            state_o.mode = MODE_ALT2;
          end else if (sel_hit) begin
            state_o.mode = MODE_DISABLED;
            state_o.bank = sel_bank;
          end
        end
        MODE_ALT2: begin
          if ((addr_i & ALT3_MASK) == ALT3_VALUE) begin
            state_o.mode     = MODE_ALT3;
            state_o.alt_pend = addr_i[BankW-1:0];
          end else begin
            state_o.mode = MODE_ENABLED;
          end
        end
        MODE_ALT3: begin
          if ((addr_i & ALT4_MASK) == ALT4_VALUE) begin
            state_o.mode = MODE_DISABLED;
            state_o.bank = state_i.alt_pend;
          end
        end
        MODE_BIT1: begin
          if (sel_hit) begin
            state_o.mode     = MODE_BIT2;
            state_o.bit_pend = state_i.bank;
            state_o.toggle   = '0;
          end
        end
        MODE_BIT2: begin
          if (bit2_x == BIT2_CLR0) begin
            state_o.bit_pend[0] = 1'b0;
            state_o.toggle      = ~state_i.toggle;
          end else if (bit2_x == BIT2_SET0) begin
            state_o.bit_pend[0] = 1'b1;
            state_o.toggle      = ~state_i.toggle;
          end else if (bit2_x == BIT2_CLR1) begin
            state_o.bit_pend[1] = 1'b0;
            state_o.toggle      = ~state_i.toggle;
          end else if (bit2_x == BIT2_SET1) begin
            state_o.bit_pend[1] = 1'b1;
            state_o.toggle      = ~state_i.toggle;
          end else if ((addr_i & BIT3_MASK) == BIT3_VALUE) begin
            state_o.mode = MODE_BIT3;
          end
        end
        MODE_BIT3: begin
          if (sel_hit) begin
            state_o.mode = MODE_DISABLED;
            state_o.bank = state_i.bit_pend;
          end
        end
        default: begin
          state_o = state_i;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/rom_bank_protection_sequencer_top.sv
// rom bank protection sequencer
//
// addr_i carries one ROM access address per word; bank_o returns, for each
// accepted address, the bank (0 to 3) selected after that access. every
// address gets exactly one bank word, in order.
//
// the sequence state and the bank are registered at the edge that accepts the
// address, and the bank word is valid in the next cycle.
// throughput: one address per cycle unless bank_o stalls; the state update
// is one pass of compare and select logic from address into state register.
//
// addr_i.ready stays high while the output word is taken in the same cycle
// or no word is waiting; when the receiver stalls, the single output word
// holds and addr_i.ready drops until it is taken.
//
// reset (rst_ni low, asynchronous) gives bank 3 with the sequencer disabled;
// an access to address zero arms it.

`default_nettype none

module rom_bank_protection_sequencer_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  rbps_addr_if.sink         addr_i,
  rbps_bank_if.source       bank_o
);
  import rbps_pkg::*;

  seq_state_t state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_acc;

  assign addr_i.ready = !out_valid_q || bank_o.ready;
  assign in_acc       = addr_i.valid && addr_i.ready;

  rbps_step u_step (
    .state_i (state_q),
    .addr_i  (addr_i.address),
    .state_o (state_d)
  );

  assign out_valid_d = in_acc || (out_valid_q && !bank_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode     <= MODE_DISABLED;
      state_q.bank     <= RESET_BANK;
      state_q.alt_pend <= '0;
      state_q.bit_pend <= '0;
      state_q.toggle   <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      if (in_acc) begin
        state_q <= state_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // the state bank is the result word; it only moves on an accepted address
  assign bank_o.valid = out_valid_q;
  assign bank_o.bank  = state_q.bank;

  a_mode_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q.mode))
    else $error("sequencer mode not one-hot");

  a_zero_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && addr_i.address == '0) |=> (state_q.mode == MODE_ENABLED))
    else $error("address zero did not arm the sequencer");

  a_bank_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.bank != $past(state_q.bank)) |-> $past(in_acc))
    else $error("bank changed without an accepted address");

  a_word_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted address produced no bank word");

  a_disabled_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && state_q.mode == MODE_DISABLED && addr_i.address != '0)
      |=> ($stable(state_q.bank) && state_q.mode == MODE_DISABLED))
    else $error("disabled sequencer reacted to an address");

endmodule

`default_nettype wire
